[src/crz_pkg.sv]
package crz_pkg;

    localparam int COORD_W     = 10;
    localparam int OFS_W       = 11;
    localparam int DEC_W       = 14;
    localparam int NPTS        = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef logic [COORD_W-1:0] coord_t;

    // One step's worth of mirrored pixels, ready for serialising
    typedef struct packed {
        coord_t [NPTS-1:0] px;
        coord_t [NPTS-1:0] py;
        logic   [NPTS-1:0] keep;
        logic              done;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[src/circle_rasterizer.sv]
// Midpoint circle rasterizer with canvas clipping.
// Input channel (s_*): op selects start (latch center_x, center_y, radius)
// or step (emit the eight mirrored pixels of the current offset, then
// advance). A start word gives no result; a step word gives one result
// word per pixel that falls inside the canvas, in octant order, or a
// single word with plot_valid low when none does. m_last marks the final
// word of each step; m_done_res is high on every word of the step that
// finishes the circle, and on the word of a step issued with no circle.
// Path: with the back end idle, the first result word of a step passes through
// the job queue, the job register and the result register before it is shown.
// Throughput: the back end issues one result per cycle while the receiver
// accepts; a start word only updates the front end. A two-entry job queue
// between front and back lets the front keep accepting while the back end drains.
// When the receiver stalls (m_ready low) the result register holds, the
// back end stops and, once the queue fills, s_ready drops.
// Reset (aresetn low, synchronous) empties the queue and the output
// register and leaves no circle in progress.
module circle_rasterizer
    import crz_pkg::*;
#(
    parameter int CANVAS_SIZE = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [COORD_W-1:0] s_center_x,
    input  logic [COORD_W-1:0] s_center_y,
    input  logic [COORD_W-1:0] s_radius,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COORD_W-1:0] m_plot_x,
    output logic [COORD_W-1:0] m_plot_y,
    output logic               m_plot_valid,
    output logic               m_done_res,
    output logic               m_last
);

    q_status_t q_status;
    job_t      wr_job;
    job_t      rd_job;
    logic      push;
    logic      pop;

    crz_front #(
        .CANVAS_SIZE(CANVAS_SIZE)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_center_x(s_center_x),
        .s_center_y(s_center_y),
        .s_radius  (s_radius),
        .q_status  (q_status),
        .push      (push),
        .job       (wr_job)
    );

    crz_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .status (q_status)
    );

    crz_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_status    (q_status),
        .q_job       (rd_job),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_plot_x    (m_plot_x),
        .m_plot_y    (m_plot_y),
        .m_plot_valid(m_plot_valid),
        .m_done_res  (m_done_res),
        .m_last      (m_last)
    );

endmodule

[src/crz_front.sv]
module crz_front
    import crz_pkg::*;
#(
    parameter int CANVAS_SIZE = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [COORD_W-1:0] s_center_x,
    input  logic [COORD_W-1:0] s_center_y,
    input  logic [COORD_W-1:0] s_radius,
    input  q_status_t          q_status,
    output logic               push,
    output job_t               job
);

    localparam logic [12:0] CANVAS_LIM = 13'(CANVAS_SIZE);

    logic [COORD_W-1:0] center_col_reg, center_col_next;
    logic [COORD_W-1:0] center_row_reg, center_row_next;
    logic [OFS_W-1:0]   minor_reg, minor_next;
    logic [OFS_W-1:0]   major_reg, major_next;
    logic [DEC_W-1:0]   decision_reg, decision_next;
    logic               active_reg, active_next;

    logic               accept;
    logic               step_done;
    logic signed [11:0] minor_inc;
    logic signed [11:0] major_dec;
    logic signed [15:0] dec_sum;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && (s_op == OP_STEP);

    // mirrored points and clip test
    always_comb begin
        logic [OFS_W-1:0]   a, b;
        logic signed [12:0] sx, sy, px, py;
        logic               in_x, in_y;
        sx = $signed({3'b000, center_col_reg});
        sy = $signed({3'b000, center_row_reg});
        for (int i = 0; i < NPTS; i++) begin
            a = i[2] ? major_reg : minor_reg;
            b = i[2] ? minor_reg : major_reg;
            px = i[0] ? sx - $signed({2'b00, a}) : sx + $signed({2'b00, a});
            py = i[1] ? sy - $signed({2'b00, b}) : sy + $signed({2'b00, b});
            in_x = !px[12] && ({1'b0, px[11:0]} < CANVAS_LIM);
            in_y = !py[12] && ({1'b0, py[11:0]} < CANVAS_LIM);
            job.px[i]   = px[COORD_W-1:0];
            job.py[i]   = py[COORD_W-1:0];
            job.keep[i] = active_reg && in_x && in_y;
        end
        job.done = step_done || !active_reg;
    end

    // decision update
    always_comb begin
        logic signed [15:0] d;
        d         = 16'($signed(decision_reg));
        minor_inc = $signed({1'b0, minor_reg}) + 12'sd1;
        if (d > 16'sd0) begin
            major_dec = $signed({1'b0, major_reg}) - 12'sd1;
            dec_sum   = d + 16'(($signed(13'(minor_inc)) - $signed(13'(major_dec))) * 4) + 16'sd10;
        end else begin
            major_dec = $signed({1'b0, major_reg});
            dec_sum   = d + 16'($signed(16'(minor_inc)) * 4) + 16'sd6;
        end
        step_done = major_dec < minor_inc;
    end

    always_comb begin
        center_col_next = center_col_reg;
        center_row_next = center_row_reg;
        minor_next      = minor_reg;
        major_next      = major_reg;
        decision_next   = decision_reg;
        active_next     = active_reg;
        if (accept) begin
            unique case (s_op)
                OP_START: begin
                    center_col_next = s_center_x;
                    center_row_next = s_center_y;
                    minor_next      = '0;
                    major_next      = {1'b0, s_radius};
                    decision_next   = DEC_W'(14'sd3 - 14'($signed({1'b0, s_radius}) * 2));
                    active_next     = 1'b1;
                end
                OP_STEP: begin
                    if (active_reg) begin
                        minor_next    = minor_inc[OFS_W-1:0];
                        major_next    = major_dec[OFS_W-1:0];
                        decision_next = dec_sum[DEC_W-1:0];
                        if (step_done) begin
                            active_next = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_col_reg <= '0;
            center_row_reg <= '0;
            minor_reg      <= '0;
            major_reg      <= '0;
            decision_reg   <= '0;
            active_reg     <= 1'b0;
        end else begin
            center_col_reg <= center_col_next;
            center_row_reg <= center_row_next;
            minor_reg      <= minor_next;
            major_reg      <= major_next;
            decision_reg   <= decision_next;
            active_reg     <= active_next;
        end
    end

    a_start_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_op == OP_START) |=> active_reg)
        else $error("start word did not arm the circle");

    a_idle_step_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !active_reg) |-> (job.done && job.keep == '0))
        else $error("step while idle must give one finished empty job");

endmodule

[src/crz_queue.sv]
module crz_queue
    import crz_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  job_t      wr_job,
    input  logic      pop,
    output job_t      rd_job,
    output q_status_t status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign rd_job       = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && status.full && !pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && status.empty))
        else $error("queue read while empty");

endmodule

[src/crz_back.sv]
module crz_back
    import crz_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  q_status_t          q_status,
    input  job_t               q_job,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COORD_W-1:0] m_plot_x,
    output logic [COORD_W-1:0] m_plot_y,
    output logic               m_plot_valid,
    output logic               m_done_res,
    output logic               m_last
);

    localparam int IDX_W = $clog2(NPTS);

    job_t               cur_reg, cur_next;
    logic               cur_valid_reg, cur_valid_next;
    logic [NPTS-1:0]    pend_reg, pend_next;

    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic               out_pv_reg, out_done_reg, out_last_reg;

    logic               out_free;
    logic               emit;
    logic               emit_last;
    logic [IDX_W-1:0]   sel;
    logic [NPTS-1:0]    pend_left;

    assign out_free = !out_valid_reg || m_ready;
    assign emit     = cur_valid_reg && out_free;

    // lowest pending pixel goes first
    always_comb begin
        sel = '0;
        for (int i = NPTS - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                sel = IDX_W'(i);
            end
        end
        pend_left = pend_reg & ~(NPTS'(1) << sel);
        emit_last = (pend_reg == '0) || (pend_left == '0);
    end

    assign pop = !q_status.empty && (!cur_valid_reg || (emit && emit_last));

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        pend_next      = pend_reg;
        if (emit) begin
            pend_next = pend_left;
            if (emit_last) begin
                cur_valid_next = 1'b0;
            end
        end
        if (pop) begin
            cur_next       = q_job;
            pend_next      = q_job.keep;
            cur_valid_next = 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
        if (emit) begin
            // empty keep mask: one invalid word
            if (pend_reg == '0) begin
                out_x_reg  <= '0;
                out_y_reg  <= '0;
                out_pv_reg <= 1'b0;
            end else begin
                out_x_reg  <= cur_reg.px[sel];
                out_y_reg  <= cur_reg.py[sel];
                out_pv_reg <= 1'b1;
            end
            out_done_reg <= cur_reg.done;
            out_last_reg <= emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_plot_x     = out_x_reg;
    assign m_plot_y     = out_y_reg;
    assign m_plot_valid = out_pv_reg;
    assign m_done_res   = out_done_reg;
    assign m_last       = out_last_reg;

    a_invalid_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_plot_valid) |-> m_last)
        else $error("invalid word must close its step");

    a_pop_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && cur_valid_reg) |-> (emit && emit_last))
        else $error("job overwritten before its last word left");

endmodule
